### design/rea_pkg.sv
// Shared types, constants and the reciprocal table for the RGBA edge smoothing filter.
`timescale 1ns / 1ps
package rea_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int POS_W         = 13;   // holds any width or height up to 4096
  localparam int CNT_W         = 25;   // pixel index up to 4096 * 4096
  localparam int SUM_W         = 12;   // nine 8-bit channels
  localparam int DIV_W         = 4;    // divisor 1..10
  localparam int RCP_W         = 17;
  localparam int RCP_SHIFT     = 16;
  localparam int Q_DEPTH       = 8;
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MY     = 3'd6;

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_ALPHA = 2'd1;
  localparam logic [1:0] MODE_MEAN  = 2'd2;

  typedef struct packed {
    logic [10:0] width;
    logic [12:0] height;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] mx;
    logic [12:0] my;
  } cfg_t;

  // one classified pixel, waiting for its divide
  typedef struct packed {
    logic [1:0]             mode;
    logic [3:0][SUM_W-1:0]  sums;   // channel k at index k (0 red .. 3 alpha)
    logic [DIV_W-1:0]       div;
    logic [31:0]            centre;
    logic                   last;
  } entry_t;

  // ceil(2^16 / d): exact floor division for numerators below 4096
  function automatic logic [RCP_W-1:0] recip(input logic [DIV_W-1:0] d);
    logic [RCP_W-1:0] r;
    unique case (d)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

### design/rea_front.sv
// Front end: line stores, 3x3 window, position tracking and pixel classification.
`timescale 1ns / 1ps
module rea_front #(
  parameter int MAX_WIDTH = rea_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rea_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic [7:0]                   in_alpha,
  input  logic [rea_pkg::Q_CNT_W-1:0]  q_count,
  output logic                         push,
  output rea_pkg::entry_t              push_entry
);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PW    = rea_pkg::POS_W;
  localparam int YW    = rea_pkg::CNT_W;
  localparam int RC_W  = $clog2(rea_pkg::CNT_W + 1);

  logic [PW-1:0] w_eff, h_eff;
  logic [rea_pkg::CNT_W-1:0] total_m1;

  logic [COL_W-1:0] in_column, col;
  logic [1:0]       in_row;
  logic [rea_pkg::CNT_W-1:0] out_count;
  logic [COL_W-1:0] ox;
  logic [YW-1:0]    oy;

  logic acc, emit, last;
  logic [31:0] data;

  logic [31:0] above  [MAX_WIDTH];
  logic [31:0] middle [MAX_WIDTH];
  logic [31:0] top_q, mid_q, fwd_px;
  logic        fwd;

  logic             s1v, s1_emit, s1_last;
  logic [COL_W-1:0] s1_col, s1_ox;
  logic [YW-1:0]    s1_oy;
  logic [31:0]      s1_data;

  logic             s2v, s2_last;
  logic [COL_W-1:0] s2_ox;
  logic [YW-1:0]    s2_oy;

  logic [2:0][2:0][31:0] win;   // [column][row]

  // output position recompute after a width change: serial out_count / width
  logic [PW-1:0]             w_seen;
  logic                      rc_start, rc_busy, rc_bit;
  logic [RC_W-1:0]           rc_left;
  logic [rea_pkg::CNT_W-1:0] rc_num, rc_num_next;
  logic [PW:0]               rc_try, rc_rem, rc_rem_next;

  always_comb begin
    if (cfg.width == 11'd0) w_eff = PW'(1);
    else if ({2'b00, cfg.width} > PW'(MAX_WIDTH)) w_eff = PW'(MAX_WIDTH);
    else w_eff = {2'b00, cfg.width};
    if (cfg.height == 13'd0) h_eff = PW'(1);
    else if (cfg.height > PW'(rea_pkg::MAX_HEIGHT)) h_eff = PW'(rea_pkg::MAX_HEIGHT);
    else h_eff = cfg.height;
  end

  assign total_m1 = rea_pkg::CNT_W'(w_eff) * rea_pkg::CNT_W'(h_eff)
                    - rea_pkg::CNT_W'(1);

  assign rc_start    = (w_eff != w_seen) && (out_count != '0);
  assign rc_busy     = rc_left != '0;
  assign rc_try      = {rc_rem[PW-1:0], rc_num[rea_pkg::CNT_W-1]};
  assign rc_bit      = rc_try >= {1'b0, w_eff};
  assign rc_rem_next = rc_bit ? (rc_try - {1'b0, w_eff}) : rc_try;
  assign rc_num_next = {rc_num[rea_pkg::CNT_W-2:0], rc_bit};

  assign in_stall = rc_start || rc_busy
                 || ((rea_pkg::Q_CNT_W'(q_count) + rea_pkg::Q_CNT_W'(s1v)
                     + rea_pkg::Q_CNT_W'(s2v)) >= rea_pkg::Q_CNT_W'(rea_pkg::Q_DEPTH));
  assign acc  = in_valid && !in_stall;
  assign col  = (PW'(in_column) >= w_eff) ? COL_W'(w_eff - PW'(1)) : in_column;
  assign emit = (in_row >= 2'd2) || (in_row == 2'd1 && col != '0);
  assign last = emit && (out_count >= total_m1);
  assign data = kind ? 32'd0 : {in_alpha, in_blue, in_green, in_red};

  always_ff @(posedge clk) begin
    w_seen <= w_eff;
    if (rst) begin
      rc_left <= '0;
    end else if (rc_start) begin
      rc_left <= RC_W'(rea_pkg::CNT_W);
      rc_num  <= out_count;
      rc_rem  <= '0;
    end else if (rc_busy) begin
      rc_left <= rc_left - RC_W'(1);
      rc_num  <= rc_num_next;
      rc_rem  <= rc_rem_next;
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_count <= '0;
      ox        <= '0;
      oy        <= '0;
    end else if (acc) begin
      if (last) begin
        in_column <= '0;
        in_row    <= '0;
        out_count <= '0;
        ox        <= '0;
        oy        <= '0;
      end else begin
        if (emit) begin
          out_count <= out_count + rea_pkg::CNT_W'(1);
          if (PW'(ox) + PW'(1) >= w_eff) begin
            ox <= '0;
            oy <= oy + YW'(1);
          end else begin
            ox <= ox + COL_W'(1);
          end
        end
        if (PW'(col) + PW'(1) >= w_eff) begin
          in_column <= '0;
          if (in_row != 2'd2) in_row <= in_row + 2'd1;
        end else begin
          in_column <= col + COL_W'(1);
        end
      end
    end else if (rc_left == RC_W'(1)) begin
      ox <= COL_W'(rc_rem_next);
      oy <= rc_num_next;
    end
  end

  // line stores; the above store is written in the cycle after acceptance, hence the forward
  always_ff @(posedge clk) begin
    if (acc) begin
      mid_q       <= middle[col];
      middle[col] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      top_q  <= above[col];
      fwd    <= s1v && (s1_col == col);
      fwd_px <= mid_q;
    end
    if (s1v) above[s1_col] <= mid_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      win <= '0;
    end else begin
      s1v <= acc;
      s2v <= s1v && s1_emit;
      if (s1v) begin
        win[0]    <= win[1];
        win[1]    <= win[2];
        win[2][0] <= fwd ? fwd_px : top_q;
        win[2][1] <= mid_q;
        win[2][2] <= s1_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col  <= col;
      s1_data <= data;
      s1_emit <= emit;
      s1_last <= last;
      s1_ox   <= ox;
      s1_oy   <= oy;
    end
    if (s1v) begin
      s2_ox   <= s1_ox;
      s2_oy   <= s1_oy;
      s2_last <= s1_last;
    end
  end

  // classification of the centre pixel
  logic [2:0] okx, oky;
  logic       band, inner;
  logic [rea_pkg::SUM_W-1:0] asum;
  logic [3:0][rea_pkg::SUM_W-1:0] msum;
  logic [rea_pkg::DIV_W-1:0] acnt, mcnt;
  logic [31:0] c;

  always_comb begin
    c      = win[1][1];
    okx[0] = s2_ox != '0;
    okx[1] = 1'b1;
    okx[2] = (PW'(s2_ox) + PW'(1)) < w_eff;
    oky[0] = s2_oy != '0;
    oky[1] = 1'b1;
    oky[2] = ({1'b0, s2_oy} + (YW+1)'(1)) < (YW+1)'(h_eff);
    band   = ({2'b00, s2_ox} < {1'b0, cfg.mx})
          || (({2'b00, s2_ox} + {1'b0, cfg.mx}) > {1'b0, w_eff})
          || ({1'b0, s2_oy} < (YW+1)'(cfg.my))
          || (({1'b0, s2_oy} + (YW+1)'(cfg.my)) > (YW+1)'(h_eff));
    inner  = (c[7:0] == cfg.red) && (c[15:8] == cfg.green) && (c[23:16] == cfg.blue);
    asum   = '0;
    acnt   = '0;
    msum   = '0;
    mcnt   = '0;
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        if (okx[dx] && oky[dy]) begin
          asum = asum + rea_pkg::SUM_W'(win[dx][dy][31:24]);
          if (win[dx][dy][31:24] != 8'd0) begin
            acnt = acnt + rea_pkg::DIV_W'(1);
            mcnt = mcnt + rea_pkg::DIV_W'(1);
            for (int k = 0; k < 4; k++) begin
              msum[k] = msum[k] + rea_pkg::SUM_W'(win[dx][dy][8*k +: 8]);
            end
          end
        end
      end
    end
    push_entry.centre = c;
    push_entry.last   = s2_last;
    if (c[31:24] == 8'd0) begin
      push_entry.mode = rea_pkg::MODE_ALPHA;
      push_entry.sums = {asum, msum[2:0]};
      push_entry.div  = acnt + rea_pkg::DIV_W'(1);
    end else if (inner && band) begin
      push_entry.mode = rea_pkg::MODE_MEAN;
      push_entry.sums = msum;
      push_entry.div  = mcnt;
    end else begin
      push_entry.mode = rea_pkg::MODE_PASS;
      push_entry.sums = msum;
      push_entry.div  = mcnt;
    end
  end

  assign push = s2v;

endmodule

### design/rea_fifo.sv
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps
module rea_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  rea_pkg::entry_t              push_entry,
  input  logic                         pop,
  output rea_pkg::entry_t              head,
  output logic [rea_pkg::Q_CNT_W-1:0]  count
);
  localparam int PTR_W = $clog2(rea_pkg::Q_DEPTH);

  rea_pkg::entry_t   ent [rea_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;

  assign head = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + rea_pkg::Q_CNT_W'(push) - rea_pkg::Q_CNT_W'(pop);
    end
  end

endmodule

### design/rea_back.sv
// Back end: reciprocal divide of the neighbourhood sums and the output register.
`timescale 1ns / 1ps
module rea_back (
  input  logic                         clk,
  input  logic                         rst,
  input  rea_pkg::entry_t              head,
  input  logic [rea_pkg::Q_CNT_W-1:0]  count,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [7:0]                   out_alpha,
  output logic                         last_of_frame
);
  localparam int PROD_W = rea_pkg::SUM_W + rea_pkg::RCP_W;

  logic [rea_pkg::RCP_W-1:0] r;
  logic [3:0][7:0] q;
  logic [31:0] px;

  assign pop = (count != '0) && (!out_valid || !out_stall);
  assign r   = rea_pkg::recip(head.div);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [PROD_W-1:0] p;
      p    = PROD_W'(head.sums[k]) * PROD_W'(r);
      q[k] = p[rea_pkg::RCP_SHIFT +: 8];
    end
    unique case (head.mode)
      rea_pkg::MODE_ALPHA: px = {q[3], head.centre[23:0]};
      rea_pkg::MODE_MEAN:  px = q;
      default:             px = head.centre;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pop) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_red       <= px[7:0];
      out_green     <= px[15:8];
      out_blue      <= px[23:16];
      out_alpha     <= px[31:24];
      last_of_frame <= head.last;
    end
  end

endmodule

### design/rgba_edge_antialias_3x3.sv
// Top level of the RGBA 3x3 selective mean filter for edge smoothing.
//
// Pixels enter in raster order on the input channel (in_valid / in_stall);
// kind = 1 marks a drain transaction carrying no pixel. Each result leaves
// on the output channel (out_valid / out_stall) with last_of_frame set on
// the final pixel of the image. After the last pixel the host sends
// width + 1 drain transactions to flush the window.
// Results appear only after width + 1 transactions of a frame; the result
// for a pixel comes with the transaction one row plus one pixel later and,
// after that transaction's accepting edge, goes through the window shift,
// classification into the queue and the divide into the output register.
// Throughput: one transaction per cycle while in_stall is low. A width write
// in mid-frame stalls the input during the serial output position recompute.
// Configuration writes (cfg_valid / cfg_ready) are always taken; cfg_ready
// stays high. Write them only while the block is idle.
// Reset clears counters, window, queue and output valid; the line stores
// are not cleared. When the receiver stalls, the output holds and the
// queue fills; in_stall rises once queue plus in-flight pixels reach its
// depth of eight.
`timescale 1ns / 1ps
module rgba_edge_antialias_3x3 #(
  parameter int MAX_WIDTH = rea_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_alpha,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha,
  output logic                            last_of_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rea_pkg::CFG_DATA_W-1:0]  cfg_data
);
  rea_pkg::cfg_t   cfg;
  rea_pkg::entry_t push_entry, head;
  logic            push, pop;
  logic [rea_pkg::Q_CNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 11'd1024;
      cfg.height <= 13'd1024;
      cfg.red    <= 8'd0;
      cfg.green  <= 8'd0;
      cfg.blue   <= 8'd0;
      cfg.mx     <= 11'd2;
      cfg.my     <= 13'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rea_pkg::REG_WIDTH:  cfg.width  <= cfg_data[10:0];
        rea_pkg::REG_HEIGHT: cfg.height <= cfg_data[12:0];
        rea_pkg::REG_RED:    cfg.red    <= cfg_data[7:0];
        rea_pkg::REG_GREEN:  cfg.green  <= cfg_data[7:0];
        rea_pkg::REG_BLUE:   cfg.blue   <= cfg_data[7:0];
        rea_pkg::REG_MX:     cfg.mx     <= cfg_data[10:0];
        rea_pkg::REG_MY:     cfg.my     <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  rea_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .cfg,
    .in_valid, .in_stall, .kind, .in_red, .in_green, .in_blue, .in_alpha,
    .q_count, .push, .push_entry
  );

  rea_fifo u_fifo (
    .clk, .rst, .push, .push_entry, .pop, .head, .count(q_count)
  );

  rea_back u_back (
    .clk, .rst, .head, .count(q_count), .pop,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_alpha,
    .last_of_frame
  );

endmodule

### design/rea_checker.sv
// Port-level checks for the RGBA edge smoothing filter, bound to the top level.
`timescale 1ns / 1ps
module rea_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_alpha,
  input logic       last_of_frame,
  input logic       cfg_ready
);
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_alpha)
      && $stable(last_of_frame))
    else $error("stalled result changed");

  a_reset_open: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind rgba_edge_antialias_3x3 rea_checker u_rea_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .out_red, .out_alpha,
  .last_of_frame, .cfg_ready
);

### tb/rea_checker.sv
// Checker for the RGBA edge smoothing filter: predicts every result and compares.
`timescale 1ns / 1ps
module rea_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           kind,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_alpha,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     out_red,
  input  logic [7:0]                     out_green,
  input  logic [7:0]                     out_blue,
  input  logic [7:0]                     out_alpha,
  input  logic                           last_of_frame,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rea_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fails,
  output int                             pending,
  output int                             checked
);
  typedef struct packed {
    logic [31:0] px;
    logic        last;
  } smoothed_t;

  smoothed_t      smoothed_q[$];
  rea_pkg::cfg_t  regs;
  logic [31:0]    row_above[rea_pkg::MAX_WIDTH_DEF];
  logic [31:0]    row_middle[rea_pkg::MAX_WIDTH_DEF];
  logic [31:0]    win[3][3];  // [column][row]
  int             col_in, row_in, out_idx;

  task automatic report(string what, int got, int want);
    $display("checker: %s mismatch at result %0d: got %0d expected %0d",
             what, checked, got, want);
    fails++;
  endtask

  function automatic logic [31:0] smooth_pixel(int ox, int oy, int w, int h);
    logic [31:0] c;
    int          sum[4];
    int          cnt;
    bit          ok[3][3];
    bit          band;
    logic [31:0] res;
    c = win[1][1];
    cnt = 0;
    res = '0;
    for (int k = 0; k < 4; k++) sum[k] = 0;
    for (int dx = 0; dx < 3; dx++)
      for (int dy = 0; dy < 3; dy++)
        ok[dx][dy] = (ox + dx - 1 >= 0) && (oy + dy - 1 >= 0) &&
                     (ox + dx - 1 < w) && (oy + dy - 1 < h);
    if (c[31:24] == 0) begin
      for (int dx = 0; dx < 3; dx++)
        for (int dy = 0; dy < 3; dy++)
          if (ok[dx][dy]) begin
            sum[3] += win[dx][dy][31:24];
            if (win[dx][dy][31:24] != 0) cnt++;
          end
      return {8'(sum[3] / (cnt + 1)), c[23:0]};
    end
    if (c[7:0] == regs.red && c[15:8] == regs.green && c[23:16] == regs.blue) begin
      band = ox < int'(regs.mx) || ox > w - int'(regs.mx) ||
             oy < int'(regs.my) || oy > h - int'(regs.my);
      if (band) begin
        for (int dx = 0; dx < 3; dx++)
          for (int dy = 0; dy < 3; dy++)
            if (ok[dx][dy] && win[dx][dy][31:24] != 0) begin
              for (int k = 0; k < 4; k++) sum[k] += win[dx][dy][8*k +: 8];
              cnt++;
            end
        if (cnt == 0) return c;
        for (int k = 0; k < 4; k++) res[8*k +: 8] = 8'(sum[k] / cnt);
        return res;
      end
    end
    return c;
  endfunction

  // one accepted transaction through the window; may yield a result
  task automatic advance_window(logic [31:0] data);
    int          w, h, total;
    logic [31:0] top, mid;
    smoothed_t   e;
    w = int'(regs.width);
    h = int'(regs.height);
    if (w < 1) w = 1;
    if (w > rea_pkg::MAX_WIDTH_DEF) w = rea_pkg::MAX_WIDTH_DEF;
    if (h < 1) h = 1;
    if (h > rea_pkg::MAX_HEIGHT) h = rea_pkg::MAX_HEIGHT;
    total = w * h;
    if (col_in >= w) col_in = w - 1;
    top = row_above[col_in];
    mid = row_middle[col_in];
    row_above[col_in] = mid;
    row_middle[col_in] = data;
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = data;
    if (row_in >= 2 || (row_in == 1 && col_in >= 1)) begin
      e.px = smooth_pixel(out_idx % w, out_idx / w, w, h);
      e.last = out_idx >= total - 1;
      smoothed_q.insert(smoothed_q.size(), e);
      if (e.last) begin
        col_in = 0;
        row_in = 0;
        out_idx = 0;
        return;
      end
      out_idx++;
    end
    if (col_in + 1 >= w) begin
      col_in = 0;
      row_in++;
    end else begin
      col_in++;
    end
  endtask

  always @(posedge clk) begin
    smoothed_t e;
    if (rst) begin
      fails = 0;
      checked = 0;
      regs = '{width: 11'd1024, height: 13'd1024, red: 8'd0, green: 8'd0, blue: 8'd0,
               mx: 11'd2, my: 13'd10};
      for (int i = 0; i < rea_pkg::MAX_WIDTH_DEF; i++) begin
        row_above[i] = '0;
        row_middle[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      col_in = 0;
      row_in = 0;
      out_idx = 0;
      smoothed_q.delete();
    end else begin
      // a transaction at this edge still sees the registers from before it
      if (in_valid && !in_stall)
        advance_window(kind ? 32'd0 : {in_alpha, in_blue, in_green, in_red});
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rea_pkg::REG_WIDTH:  regs.width  = cfg_data[10:0];
          rea_pkg::REG_HEIGHT: regs.height = cfg_data[12:0];
          rea_pkg::REG_RED:    regs.red    = cfg_data[7:0];
          rea_pkg::REG_GREEN:  regs.green  = cfg_data[7:0];
          rea_pkg::REG_BLUE:   regs.blue   = cfg_data[7:0];
          rea_pkg::REG_MX:     regs.mx     = cfg_data[10:0];
          rea_pkg::REG_MY:     regs.my     = cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (smoothed_q.size() == 0) begin
          $display("checker: result with nothing expected");
          fails++;
        end else begin
          e = smoothed_q.pop_front();
          if (out_red   !== e.px[7:0])   report("red",   out_red,   e.px[7:0]);
          if (out_green !== e.px[15:8])  report("green", out_green, e.px[15:8]);
          if (out_blue  !== e.px[23:16]) report("blue",  out_blue,  e.px[23:16]);
          if (out_alpha !== e.px[31:24]) report("alpha", out_alpha, e.px[31:24]);
          if (last_of_frame !== e.last)  report("last",  last_of_frame, e.last);
        end
        checked++;
      end
    end
    pending = smoothed_q.size();
  end
endmodule

### tb/tb.sv
// Testbench top for rgba_edge_antialias_3x3: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           kind = 1'b0;
  logic [7:0]                     in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b1;
  logic [7:0]                     out_red, out_green, out_blue, out_alpha;
  logic                           last_of_frame;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rea_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rea_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fails, pending, checked;

  // test state
  bit  no_gaps;          // stretch with back-to-back transactions on both sides
  bit  hold_request;     // asks the receiver for one long hold-off
  int  frames_done;
  int  pixels_sent;
  int  items_sent;
  int  idle_cycles;
  int  width_eff, height_eff;
  logic [7:0] fill_r, fill_g, fill_b;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rgba_edge_antialias_3x3 uut (.*);

  rea_monitor chk (.*);

  // Watchdog: a long run of cycles with no transaction on any channel means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 4000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall before each result, plus one long hold-off on request
  // so the internal queue fills and in_stall rises while the sender keeps offering.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send(logic k, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                      logic [7:0] a);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    in_red = r;
    in_green = g;
    in_blue = b;
    in_alpha = a;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Every result in, then a few cycles for anything still in the pipeline.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [rea_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = rea_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(int w, int h, int r, int g, int b, int mx, int my);
    wait_idle();
    write_reg(rea_pkg::REG_WIDTH, w);
    write_reg(rea_pkg::REG_HEIGHT, h);
    write_reg(rea_pkg::REG_RED, r);
    write_reg(rea_pkg::REG_GREEN, g);
    write_reg(rea_pkg::REG_BLUE, b);
    write_reg(rea_pkg::REG_MX, mx);
    write_reg(rea_pkg::REG_MY, my);
    width_eff  = (w % 2048 == 0) ? 1 : (w % 2048 > 1024 ? 1024 : w % 2048);
    height_eff = (h % 8192 == 0) ? 1 : (h % 8192 > 4096 ? 4096 : h % 8192);
    fill_r = 8'(r);
    fill_g = 8'(g);
    fill_b = 8'(b);
  endtask

  // Random pixel biased toward the fill colour and toward clear or opaque alpha.
  task automatic send_random_pixel();
    logic [7:0] r, g, b, a;
    int sel;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      r = fill_r;
      g = fill_g;
      b = fill_b;
    end
    case ($urandom_range(0, 3))
      0: a = 8'd0;
      1: a = 8'd255;
      default: a = 8'($urandom);
    endcase
    send(1'b0, r, g, b, a);
    pixels_sent++;
  endtask

  // A whole frame followed by its width+1 drain transactions (drain payload is junk).
  task automatic random_frame(bit pause_midway);
    int n;
    n = width_eff * height_eff;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) begin
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_random_pixel();
    end
    for (int i = 0; i <= width_eff; i++)
      send(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    frames_done++;
  endtask

  initial begin
    logic [31:0] pattern[12];
    int w, h, mx, my, phase;
    no_gaps = 1'b0;
    hold_request = 1'b0;
    frames_done = 0;
    pixels_sent = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frame, 4x3: transparent centres, fill-colour centres inside and
    // outside the band, channel extremes; 12 pixels plus 5 drains.
    configure(4, 3, 10, 20, 30, 1, 1);
    pattern = '{32'h00_000000, 32'hFF_1E140A, 32'h80_1E140A, 32'hFF_FFFFFF,
                32'h01_1E140A, 32'h00_FFFFFF, 32'hFF_1E140A, 32'h00_1E140A,
                32'hFF_000000, 32'hFF_1E140A, 32'h00_0000FF, 32'hFF_1E140A};
    foreach (pattern[i]) begin
      send(1'b0, pattern[i][7:0], pattern[i][15:8], pattern[i][23:16],
           pattern[i][31:24]);
      pixels_sent++;
    end
    for (int i = 0; i <= 4; i++) send(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    frames_done++;

    // Register extremes: zero width/height act as one, oversized margins,
    // zero margins on a single row.
    configure(0, 0, 255, 255, 255, 0, 0);
    random_frame(1'b0);
    configure(3, 2, 0, 0, 0, 2047, 8191);
    random_frame(1'b0);
    configure(5, 1, 0, 255, 0, 0, 0);
    random_frame(1'b0);

    // Random phases with small images; one long receiver hold-off and one
    // sender pause until the block has delivered every pending result.
    phase = 0;
    while (items_sent < 1760) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      mx = $urandom_range(0, w + 1);
      my = $urandom_range(0, h + 1);
      configure(w, h, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), mx, my);
      no_gaps = (phase % 4 == 1);
      for (int f = 0; f < 3; f++) begin
        if (phase == 3 && f == 0) hold_request = 1'b1;
        random_frame(phase == 5 && f == 1);
      end
      phase++;
    end
    no_gaps = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    $display("tb: %0d frames, %0d transactions (%0d pixels), %0d results checked",
             frames_done, items_sent, pixels_sent, checked);
    $display("tb: covered register extremes, long output hold-off and a drained pause");
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
